// File: src/rvde_pkg.sv
// Shared types, codes and decode helpers for the RV64IM decode/execute core.
// No dependencies; imported by every module of the block.
package rvde_pkg;

    localparam logic [63:0] MEMORY_BYTES_DEF = 64'd262144;
    localparam logic [4:0]  SP_INDEX         = 5'd2;
    localparam logic [63:0] SIGN64           = 64'h8000_0000_0000_0000;
    localparam logic [63:0] LOW32            = 64'h0000_0000_ffff_ffff;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_EXEC  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        CAT_LOAD     = 4'd0,
        CAT_STORE    = 4'd1,
        CAT_BRANCH   = 4'd2,
        CAT_JALR     = 4'd3,
        CAT_JAL      = 4'd4,
        CAT_OPIMM    = 4'd5,
        CAT_OP       = 4'd6,
        CAT_AUIPC    = 4'd7,
        CAT_LUI      = 4'd8,
        CAT_OPIMM32  = 4'd9,
        CAT_OP32     = 4'd10,
        CAT_SYSTEM   = 4'd11,
        CAT_UNIMPL   = 4'd12
    } cat_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_DIVU, OP_REM, OP_REMU,
        OP_SLL, OP_SRL, OP_SRA, OP_AND, OP_OR, OP_XOR
    } alu_op_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_FLAG
    } state_t;

    localparam logic [6:0] F7_BASE = 7'd0;
    localparam logic [6:0] F7_MULDIV = 7'd1;
    localparam logic [6:0] F7_ALT = 7'd32;

    function automatic logic [63:0] sext32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    // Map opcode bits [6:2] to a category
    function automatic cat_t cat_lookup(input logic [4:0] opc);
        cat_t c;
        unique case (opc)
            5'b00000: c = CAT_LOAD;
            5'b00100: c = CAT_OPIMM;
            5'b00101: c = CAT_AUIPC;
            5'b00110: c = CAT_OPIMM32;
            5'b01000: c = CAT_STORE;
            5'b01100: c = CAT_OP;
            5'b01101: c = CAT_LUI;
            5'b01110: c = CAT_OP32;
            5'b11000: c = CAT_BRANCH;
            5'b11001: c = CAT_JALR;
            5'b11011: c = CAT_JAL;
            5'b11100: c = CAT_SYSTEM;
            default:  c = CAT_UNIMPL;
        endcase
        return c;
    endfunction

    // Select the register-register operation
    function automatic alu_op_t pick_r(input logic [2:0] f3, input logic [6:0] f7,
                                       input logic word);
        alu_op_t op;
        unique case (f3)
            3'd0: op = (f7 == F7_BASE) ? OP_ADD : (f7 == F7_MULDIV) ? OP_MUL :
                       (f7 == F7_ALT) ? OP_SUB : OP_NONE;
            3'd1: op = OP_SLL;
            3'd4: op = word ? OP_DIV : (f7 == F7_BASE) ? OP_XOR :
                       (f7 == F7_MULDIV) ? OP_DIV : OP_NONE;
            3'd5: op = (f7 == F7_BASE) ? OP_SRL : (f7 == F7_ALT) ? OP_SRA :
                       (word && f7 == F7_MULDIV) ? OP_DIVU : OP_NONE;
            3'd6: op = word ? OP_REM : (f7 == F7_BASE) ? OP_OR :
                       (f7 == F7_MULDIV) ? OP_REM : OP_NONE;
            default: op = word ? OP_REMU : OP_AND;
        endcase
        return op;
    endfunction

endpackage

// File: src/rvde_regfile.sv
// 32 x 64-bit register file: one write port, two registered read ports.
// Per-entry valid bits give the reset contents. Depends on rvde_pkg.
module rvde_regfile #(
    parameter logic [63:0] MEMORY_BYTES = rvde_pkg::MEMORY_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        wr_en,
    input  logic [4:0]  wr_addr,
    input  logic [63:0] wr_data,
    input  logic        rd_en,
    input  logic [4:0]  rd_addr_a,
    input  logic [4:0]  rd_addr_b,
    output logic [63:0] rd_data_a,
    output logic [63:0] rd_data_b
);
    import rvde_pkg::*;

    logic [63:0] mem [32];
    logic [31:0] vld_reg;
    logic [63:0] rst_a, rst_b;

    // Track written entries
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rst_a = (rd_addr_a == SP_INDEX) ? MEMORY_BYTES : 64'd0;
    assign rst_b = (rd_addr_b == SP_INDEX) ? MEMORY_BYTES : 64'd0;

    // Read ports; unwritten entries read as reset contents
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= vld_reg[rd_addr_a] ? mem[rd_addr_a] : rst_a;
            rd_data_b <= vld_reg[rd_addr_b] ? mem[rd_addr_b] : rst_b;
        end
    end

endmodule

// File: src/rvde_mul.sv
// Sequential 64x64 multiplier, low 64 bits, from three 32x32 partial products.
// Depends on rvde_pkg.
module rvde_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] product
);
    import rvde_pkg::*;

    logic [63:0] a_reg, b_reg, acc_reg, prod_reg;
    logic [1:0]  step_reg;
    logic        busy_reg, done_reg;
    logic [31:0] mx, my;

    // Pick the partial product for this step
    always_comb begin
        case (step_reg)
            2'd0:    begin mx = a_reg[31:0];  my = b_reg[31:0];  end
            2'd1:    begin mx = a_reg[31:0];  my = b_reg[63:32]; end
            default: begin mx = a_reg[63:32]; my = b_reg[31:0];  end
        endcase
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Multiply and accumulate
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= op_a;
            b_reg <= op_b;
        end else if (busy_reg) begin
            prod_reg <= mx * my;
            case (step_reg)
                2'd0:    acc_reg <= acc_reg;
                2'd1:    acc_reg <= prod_reg;
                default: acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
            endcase
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// File: src/rvde_div.sv
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// Depends on rvde_pkg.
module rvde_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [63:0] remainder
);
    import rvde_pkg::*;

    logic [63:0] rem_reg, quo_reg, dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [64:0] shifted, diff;

    assign shifted = {rem_reg, quo_reg[63]};
    assign diff    = shifted - {1'b0, dvs_reg};

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '1;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift, trial subtract, restore
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= diff[64] ? shifted[63:0] : diff[63:0];
            quo_reg <= {quo_reg[62:0], ~diff[64]};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: src/rv64im_decode_execute_core.sv
// RV64IM decode/execute core: register file, decoder, ALU, multiply and divide.
// Write and ignored modes give no result; the core stays idle, ready for the next transaction.
// One transaction in work at a time: the next is taken only after the result is loaded
// into the output register, which a held result can delay. The divider loop sets the worst case.
// Sync active-low reset: control to idle, register file to zeros, entry 2 = MEMORY_BYTES.
module rv64im_decode_execute_core #(
    parameter logic [63:0] MEMORY_BYTES = rvde_pkg::MEMORY_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [31:0]        s_instruction,
    input  logic [63:0]        s_pc,
    input  logic [4:0]         s_reg_index,
    input  logic signed [63:0] s_reg_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_category,
    output logic               m_not_32bit,
    output logic [4:0]         m_dest_reg,
    output logic [2:0]         m_funct3,
    output logic [6:0]         m_funct7,
    output logic signed [12:0] m_offset,
    output logic signed [63:0] m_result,
    output logic               m_flag_n,
    output logic               m_flag_z,
    output logic               m_flag_c,
    output logic               m_flag_v
);
    import rvde_pkg::*;

    state_t state_reg, state_next;

    logic        accept, out_free, out_load, mul_start, div_start;
    logic        wr_en;
    logic [4:0]  rd_addr_a;
    logic [63:0] rd_data_a, rd_data_b;

    // captured transaction
    mode_t       mode_reg;
    logic [31:0] ins_reg;
    logic [63:0] pc_reg;

    // working registers
    logic [63:0] l_reg, r_reg, res_reg;
    alu_op_t     op_reg;
    logic        word_reg, flag_en_reg, neg_reg;
    logic [3:0]  cat_reg;
    logic        nb_reg;
    logic [4:0]  rd_reg;
    logic [2:0]  f3_reg;
    logic [6:0]  f7_reg;
    logic [12:0] off_reg;

    // output registers
    logic        m_valid_reg;
    logic [3:0]  o_cat_reg;
    logic        o_nb_reg, o_fn_reg, o_fz_reg, o_fc_reg, o_fv_reg;
    logic [4:0]  o_rd_reg;
    logic [2:0]  o_f3_reg;
    logic [6:0]  o_f7_reg;
    logic [12:0] o_off_reg;
    logic [63:0] o_res_reg;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign wr_en    = accept && (s_mode == MODE_WRITE);
    assign rd_addr_a = (s_mode == MODE_READ) ? s_reg_index : s_instruction[19:15];

    rvde_regfile #(.MEMORY_BYTES(MEMORY_BYTES)) u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_en),
        .wr_addr   (s_reg_index),
        .wr_data   (s_reg_value),
        .rd_en     (accept),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (s_instruction[24:20]),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // ---------------- decode (READ state) ----------------
    cat_t        d_cat;
    alu_op_t     d_op;
    logic [63:0] d_l, d_r, d_immi, d_uimm;
    logic [4:0]  d_rd;
    logic [2:0]  d_f3, d_f7_f3;
    logic [6:0]  d_f7;
    logic [12:0] d_off;
    logic        d_word, d_is32, d_sra;

    assign d_is32 = (ins_reg[1:0] == 2'b11);
    assign d_immi = {{52{ins_reg[31]}}, ins_reg[31:20]};
    assign d_uimm = {{32{ins_reg[31]}}, ins_reg[31:12], 12'd0};
    assign d_sra  = (ins_reg[31:30] != 2'b00);
    assign d_f7_f3 = ins_reg[14:12];

    always_comb begin
        d_cat  = cat_lookup(ins_reg[6:2]);
        d_op   = OP_NONE;
        d_l    = '0;
        d_r    = '0;
        d_rd   = '0;
        d_f3   = '0;
        d_f7   = '0;
        d_off  = '0;
        d_word = 1'b0;
        unique case (d_cat)
            CAT_LOAD, CAT_JALR: begin
                d_rd = ins_reg[11:7]; d_f3 = d_f7_f3;
                d_l = rd_data_a; d_r = d_immi; d_op = OP_ADD;
            end
            CAT_STORE: begin
                d_f3  = d_f7_f3;
                d_off = {ins_reg[31], ins_reg[31:25], ins_reg[11:7]};
                d_l = rd_data_a; d_r = {{51{d_off[12]}}, d_off}; d_op = OP_ADD;
            end
            CAT_BRANCH: begin
                d_f3  = d_f7_f3;
                d_off = {ins_reg[31], ins_reg[7], ins_reg[30:25], ins_reg[11:8], 1'b0};
                d_l = rd_data_a; d_r = rd_data_b; d_op = OP_SUB;
            end
            CAT_OPIMM: begin
                d_rd = ins_reg[11:7]; d_f3 = d_f7_f3;
                d_l = rd_data_a; d_r = d_immi;
                case (d_f7_f3)
                    3'd0:    d_op = OP_ADD;
                    3'd1:    d_op = OP_SLL;
                    3'd4:    d_op = OP_XOR;
                    3'd5:    d_op = d_sra ? OP_SRA : OP_SRL;
                    3'd6:    d_op = OP_OR;
                    3'd7:    d_op = OP_AND;
                    default: d_op = OP_NONE;
                endcase
            end
            CAT_OPIMM32: begin
                d_rd = ins_reg[11:7]; d_f3 = d_f7_f3; d_word = 1'b1;
                d_l = sext32(rd_data_a); d_r = d_immi;
                case (d_f7_f3)
                    3'd0:    d_op = OP_ADD;
                    3'd1:    d_op = OP_SLL;
                    3'd5:    d_op = d_sra ? OP_SRA : OP_SRL;
                    default: d_op = OP_NONE;
                endcase
            end
            CAT_OP: begin
                d_rd = ins_reg[11:7]; d_f3 = d_f7_f3; d_f7 = ins_reg[31:25];
                d_l = rd_data_a; d_r = rd_data_b;
                d_op = pick_r(d_f7_f3, ins_reg[31:25], 1'b0);
            end
            CAT_OP32: begin
                d_rd = ins_reg[11:7]; d_f3 = d_f7_f3; d_f7 = ins_reg[31:25];
                d_word = 1'b1;
                d_l = sext32(rd_data_a); d_r = sext32(rd_data_b);
                d_op = pick_r(d_f7_f3, ins_reg[31:25], 1'b1);
            end
            CAT_AUIPC: begin
                d_rd = ins_reg[11:7]; d_l = pc_reg; d_r = d_uimm; d_op = OP_ADD;
            end
            CAT_LUI: begin
                d_rd = ins_reg[11:7]; d_r = d_uimm; d_op = OP_ADD;
            end
            CAT_JAL: begin
                d_rd = ins_reg[11:7];
            end
            CAT_SYSTEM: begin
                d_rd = ins_reg[11:7]; d_f3 = d_f7_f3;
            end
            default: begin
                d_op = OP_NONE;
            end
        endcase
    end

    // ---------------- ALU and divide setup (EXEC state) ----------------
    logic [5:0]  sh;
    logic [63:0] alu_x, srl_src, div_a, div_b, spec_val;
    logic        is_mul, is_div, is_sdiv, div_spec, div_neg, b_zero;
    logic [63:0] mul_p, div_q, div_r, div_x, div_fix;
    logic        mul_done, div_done;

    assign sh      = word_reg ? {1'b0, r_reg[4:0]} : r_reg[5:0];
    assign srl_src = word_reg ? {32'd0, l_reg[31:0]} : l_reg;
    assign is_mul  = (op_reg == OP_MUL);
    assign is_sdiv = (op_reg == OP_DIV) || (op_reg == OP_REM);
    assign is_div  = is_sdiv || (op_reg == OP_DIVU) || (op_reg == OP_REMU);

    always_comb begin
        case (op_reg)
            OP_ADD:  alu_x = l_reg + r_reg;
            OP_SUB:  alu_x = l_reg - r_reg;
            OP_SLL:  alu_x = l_reg << sh;
            OP_SRL:  alu_x = srl_src >> sh;
            OP_SRA:  alu_x = $unsigned($signed(l_reg) >>> sh);
            OP_AND:  alu_x = l_reg & r_reg;
            OP_OR:   alu_x = l_reg | r_reg;
            OP_XOR:  alu_x = l_reg ^ r_reg;
            default: alu_x = '0;
        endcase
    end

    // Special divide cases and operand magnitudes
    always_comb begin
        div_neg  = 1'b0;
        div_a    = {32'd0, l_reg[31:0]};
        div_b    = {32'd0, r_reg[31:0]};
        if (is_sdiv) begin
            b_zero   = (r_reg == 64'd0);
            div_spec = b_zero || (l_reg == SIGN64 && r_reg == '1);
            if (b_zero) begin
                spec_val = (op_reg == OP_REM) ? l_reg : '1;
            end else begin
                spec_val = (op_reg == OP_REM) ? 64'd0 : SIGN64;
            end
            div_a   = l_reg[63] ? (64'd0 - l_reg) : l_reg;
            div_b   = r_reg[63] ? (64'd0 - r_reg) : r_reg;
            div_neg = (op_reg == OP_REM) ? l_reg[63] : (l_reg[63] ^ r_reg[63]);
        end else begin
            b_zero   = (r_reg[31:0] == 32'd0);
            div_spec = b_zero;
            spec_val = (op_reg == OP_REMU) ? (l_reg & LOW32) : LOW32;
        end
    end

    rvde_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (l_reg),
        .op_b    (r_reg),
        .done    (mul_done),
        .product (mul_p)
    );

    rvde_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign div_x   = ((op_reg == OP_REM) || (op_reg == OP_REMU)) ? div_r : div_q;
    assign div_fix = neg_reg ? (64'd0 - div_x) : div_x;

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_mode == MODE_READ || s_mode == MODE_EXEC)) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = (mode_reg == MODE_READ || !d_is32) ? ST_FLAG : ST_EXEC;
            end
            ST_EXEC: begin
                if (is_mul) begin
                    state_next = ST_MUL;
                end else if (is_div && !div_spec) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_FLAG;
                end
            end
            ST_MUL: begin
                if (mul_done) state_next = ST_FLAG;
            end
            ST_DIV: begin
                if (div_done) state_next = ST_FLAG;
            end
            ST_FLAG: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- state outputs ----------------
    always_comb begin
        s_ready   = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_EXEC: begin
                mul_start = is_mul;
                div_start = is_div && !div_spec;
            end
            ST_FLAG: out_load = out_free;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the transaction
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg <= mode_t'(s_mode);
            ins_reg  <= s_instruction;
            pc_reg   <= s_pc;
        end
    end

    // Working registers: decode, execute, finish
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_READ: begin
                l_reg    <= d_l;
                r_reg    <= d_r;
                op_reg   <= d_op;
                word_reg <= d_word;
                rd_reg   <= d_rd;
                f3_reg   <= d_f3;
                f7_reg   <= d_f7;
                off_reg  <= d_off;
                if (mode_reg == MODE_READ) begin
                    cat_reg     <= CAT_LOAD;
                    nb_reg      <= 1'b0;
                    flag_en_reg <= 1'b0;
                    res_reg     <= rd_data_a;
                    rd_reg      <= '0;
                    f3_reg      <= '0;
                    f7_reg      <= '0;
                    off_reg     <= '0;
                end else if (!d_is32) begin
                    cat_reg     <= CAT_UNIMPL;
                    nb_reg      <= 1'b1;
                    flag_en_reg <= 1'b0;
                    res_reg     <= '0;
                    rd_reg      <= '0;
                    f3_reg      <= '0;
                    f7_reg      <= '0;
                    off_reg     <= '0;
                end else begin
                    cat_reg     <= d_cat;
                    nb_reg      <= 1'b0;
                    flag_en_reg <= 1'b1;
                end
            end
            ST_EXEC: begin
                neg_reg <= div_neg;
                if (is_div) begin
                    res_reg <= word_reg ? sext32(spec_val) : spec_val;
                end else begin
                    res_reg <= word_reg ? sext32(alu_x) : alu_x;
                end
            end
            ST_MUL: begin
                if (mul_done) res_reg <= word_reg ? sext32(mul_p) : mul_p;
            end
            ST_DIV: begin
                if (div_done) res_reg <= word_reg ? sext32(div_fix) : div_fix;
            end
            default: ;
        endcase
    end

    // Load the output register with fields and flags
    always_ff @(posedge aclk) begin
        if (out_load) begin
            o_cat_reg <= cat_reg;
            o_nb_reg  <= nb_reg;
            o_rd_reg  <= rd_reg;
            o_f3_reg  <= f3_reg;
            o_f7_reg  <= f7_reg;
            o_off_reg <= off_reg;
            o_res_reg <= res_reg;
            o_fn_reg  <= res_reg[63];
            o_fz_reg  <= (res_reg == 64'd0);
            o_fc_reg  <= flag_en_reg &&
                         (($signed(res_reg) > $signed(l_reg)) ||
                          ($signed(res_reg) > $signed(r_reg)));
            o_fv_reg  <= flag_en_reg && (l_reg[63] == r_reg[63]) &&
                         (res_reg[63] != l_reg[63]);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_category  = o_cat_reg;
    assign m_not_32bit = o_nb_reg;
    assign m_dest_reg  = o_rd_reg;
    assign m_funct3    = o_f3_reg;
    assign m_funct7    = o_f7_reg;
    assign m_offset    = o_off_reg;
    assign m_result    = o_res_reg;
    assign m_flag_n    = o_fn_reg;
    assign m_flag_z    = o_fz_reg;
    assign m_flag_c    = o_fc_reg;
    assign m_flag_v    = o_fv_reg;

endmodule

// File: sim/rvde_checker.sv
// Result checker for the RV64IM decode/execute core: watches both channels,
// predicts each result from its own register file copy and compares fields.
// Depends on rvde_pkg.
module rvde_checker
    import rvde_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [31:0]        s_instruction,
    input  logic [63:0]        s_pc,
    input  logic [4:0]         s_reg_index,
    input  logic signed [63:0] s_reg_value,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [3:0]         m_category,
    input  logic               m_not_32bit,
    input  logic [4:0]         m_dest_reg,
    input  logic [2:0]         m_funct3,
    input  logic [6:0]         m_funct7,
    input  logic signed [12:0] m_offset,
    input  logic signed [63:0] m_result,
    input  logic               m_flag_n,
    input  logic               m_flag_z,
    input  logic               m_flag_c,
    input  logic               m_flag_v,
    output int                 err_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]  category;
        logic        not_32bit;
        logic [4:0]  dest_reg;
        logic [2:0]  funct3;
        logic [6:0]  funct7;
        logic [12:0] offset;
        logic [63:0] result;
        logic        n, z, c, v;
    } exec_out_t;

    logic [63:0] shadow_regs [32];
    exec_out_t   expected_q [$];

    function automatic logic [63:0] sx(input logic [63:0] x, input int bits);
        logic [63:0] m;
        m = 64'd1 << (bits - 1);
        return ((x & ((m << 1) - 64'd1)) ^ m) - m;
    endfunction

    function automatic logic sgt(input logic [63:0] a, input logic [63:0] b);
        return $signed(a) > $signed(b);
    endfunction

    function automatic logic [63:0] signed_div(input logic [63:0] a, input logic [63:0] b,
                                               input logic rem);
        logic [63:0] ua, ub, q;
        if (b == 0) return rem ? a : '1;
        if (a == SIGN64 && b == '1) return rem ? 64'd0 : SIGN64;
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        if (rem) begin
            q = ua % ub;
            return a[63] ? -q : q;
        end
        q = ua / ub;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic logic [63:0] alu_calc(input alu_op_t op, input logic [63:0] l,
                                             input logic [63:0] r, input logic word);
        logic [5:0]  sh;
        logic [63:0] x;
        sh = word ? {1'b0, r[4:0]} : r[5:0];
        case (op)
            OP_ADD:  x = l + r;
            OP_SUB:  x = l - r;
            OP_MUL:  x = l * r;
            OP_DIV:  x = signed_div(l, r, 1'b0);
            OP_REM:  x = signed_div(l, r, 1'b1);
            OP_DIVU: x = (r[31:0] == 0) ? LOW32 : (l & LOW32) / (r & LOW32);
            OP_REMU: x = (r[31:0] == 0) ? (l & LOW32) : (l & LOW32) % (r & LOW32);
            OP_SLL:  x = l << sh;
            OP_SRL:  x = (word ? (l & LOW32) : l) >> sh;
            OP_SRA:  x = $signed(word ? sx(l, 32) : l) >>> sh;
            OP_AND:  x = l & r;
            OP_OR:   x = l | r;
            OP_XOR:  x = l ^ r;
            default: return 64'd0;
        endcase
        return word ? sx(x, 32) : x;
    endfunction

    function automatic alu_op_t reg_reg_op(input logic [2:0] f3, input logic [6:0] f7,
                                           input logic word);
        case (f3)
            3'd0: return (f7 == 0) ? OP_ADD : (f7 == 1) ? OP_MUL :
                         (f7 == 32) ? OP_SUB : OP_NONE;
            3'd1: return OP_SLL;
            3'd4: return word ? OP_DIV : (f7 == 0) ? OP_XOR : (f7 == 1) ? OP_DIV : OP_NONE;
            3'd5: return (f7 == 0) ? OP_SRL : (f7 == 32) ? OP_SRA :
                         (word && f7 == 1) ? OP_DIVU : OP_NONE;
            3'd6: return word ? OP_REM : (f7 == 0) ? OP_OR : (f7 == 1) ? OP_REM : OP_NONE;
            default: return word ? OP_REMU : OP_AND;
        endcase
    endfunction

    function automatic exec_out_t execute_insn(input logic [31:0] ins, input logic [63:0] pc);
        exec_out_t   e;
        logic [63:0] l, r, res, immi, upper;
        alu_op_t     op;
        logic        word;
        cat_t        cat;
        e = '0;
        l = 0; r = 0; op = OP_NONE; word = 0;
        if (ins[1:0] != 2'b11) begin
            e.category = CAT_UNIMPL;
            e.not_32bit = 1;
            e.z = 1;
            return e;
        end
        immi = sx({32'd0, ins} >> 20, 12);
        upper = sx({32'd0, ins & 32'hffff_f000}, 32);
        case (ins[6:2])
            5'b00000: cat = CAT_LOAD;
            5'b00100: cat = CAT_OPIMM;
            5'b00101: cat = CAT_AUIPC;
            5'b00110: cat = CAT_OPIMM32;
            5'b01000: cat = CAT_STORE;
            5'b01100: cat = CAT_OP;
            5'b01101: cat = CAT_LUI;
            5'b01110: cat = CAT_OP32;
            5'b11000: cat = CAT_BRANCH;
            5'b11001: cat = CAT_JALR;
            5'b11011: cat = CAT_JAL;
            5'b11100: cat = CAT_SYSTEM;
            default:  cat = CAT_UNIMPL;
        endcase
        e.category = cat;
        // gather fields and operands
        case (cat)
            CAT_LOAD, CAT_JALR, CAT_OPIMM, CAT_OPIMM32, CAT_SYSTEM: begin
                e.dest_reg = ins[11:7]; e.funct3 = ins[14:12];
                l = shadow_regs[ins[19:15]]; r = immi;
            end
            CAT_STORE: begin
                e.funct3 = ins[14:12];
                e.offset = sx({52'd0, ins[31:25], ins[11:7]}, 12);
                l = shadow_regs[ins[19:15]]; r = sx({52'd0, ins[31:25], ins[11:7]}, 12);
            end
            CAT_BRANCH: begin
                e.funct3 = ins[14:12];
                e.offset = {ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
                l = shadow_regs[ins[19:15]]; r = shadow_regs[ins[24:20]];
            end
            CAT_OP, CAT_OP32: begin
                e.dest_reg = ins[11:7]; e.funct3 = ins[14:12]; e.funct7 = ins[31:25];
                l = shadow_regs[ins[19:15]]; r = shadow_regs[ins[24:20]];
            end
            CAT_AUIPC, CAT_LUI, CAT_JAL: e.dest_reg = ins[11:7];
            default: ;
        endcase
        // pick the operation
        case (cat)
            CAT_LOAD, CAT_JALR, CAT_STORE: op = OP_ADD;
            CAT_BRANCH: op = OP_SUB;
            CAT_AUIPC: begin l = pc; r = upper; op = OP_ADD; end
            CAT_LUI: begin r = upper; op = OP_ADD; end
            CAT_OP: op = reg_reg_op(e.funct3, e.funct7, 1'b0);
            CAT_OP32: begin
                word = 1; l = sx(l, 32); r = sx(r, 32);
                op = reg_reg_op(e.funct3, e.funct7, 1'b1);
            end
            CAT_OPIMM:
                case (e.funct3)
                    3'd0: op = OP_ADD;
                    3'd1: op = OP_SLL;
                    3'd4: op = OP_XOR;
                    3'd5: op = (ins[31:30] != 0) ? OP_SRA : OP_SRL;
                    3'd6: op = OP_OR;
                    3'd7: op = OP_AND;
                    default: op = OP_NONE;
                endcase
            CAT_OPIMM32: begin
                word = 1; l = sx(l, 32);
                if (e.funct3 == 0) op = OP_ADD;
                else if (e.funct3 == 1) op = OP_SLL;
                else if (e.funct3 == 5) op = (ins[31:30] != 0) ? OP_SRA : OP_SRL;
            end
            default: begin l = 0; r = 0; end
        endcase
        res = alu_calc(op, l, r, word);
        e.result = res;
        e.n = res[63];
        e.z = (res == 0);
        e.c = sgt(res, l) || sgt(res, r);
        e.v = (l[63] == r[63]) && (res[63] != l[63]);
        return e;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        err_count++;
    endtask

    exec_out_t want, got;

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (shadow_regs[i]) shadow_regs[i] = '0;
            shadow_regs[2] = MEMORY_BYTES_DEF;
            expected_q.delete();
            err_count = 0;
        end else begin
            // check a delivered transaction against the oldest prediction
            if (m_valid && m_ready) begin
                got = {m_category, m_not_32bit, m_dest_reg, m_funct3, m_funct7, m_offset,
                       m_result, m_flag_n, m_flag_z, m_flag_c, m_flag_v};
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected transaction", m_result, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.category != want.category)
                        report_mismatch("category", got.category, want.category);
                    if (got.not_32bit != want.not_32bit)
                        report_mismatch("not_32bit", got.not_32bit, want.not_32bit);
                    if (got.dest_reg != want.dest_reg)
                        report_mismatch("dest_reg", got.dest_reg, want.dest_reg);
                    if (got.funct3 != want.funct3)
                        report_mismatch("funct3", got.funct3, want.funct3);
                    if (got.funct7 != want.funct7)
                        report_mismatch("funct7", got.funct7, want.funct7);
                    if (got.offset != want.offset)
                        report_mismatch("offset", got.offset, want.offset);
                    if (got.result != want.result)
                        report_mismatch("result", got.result, want.result);
                    if (got.n != want.n) report_mismatch("flag_n", got.n, want.n);
                    if (got.z != want.z) report_mismatch("flag_z", got.z, want.z);
                    if (got.c != want.c) report_mismatch("flag_c", got.c, want.c);
                    if (got.v != want.v) report_mismatch("flag_v", got.v, want.v);
                end
            end
            // predict from an accepted input transaction
            if (s_valid && s_ready) begin
                case (mode_t'(s_mode))
                    MODE_WRITE: shadow_regs[s_reg_index] = s_reg_value;
                    MODE_READ: begin
                        want = '0;
                        want.result = shadow_regs[s_reg_index];
                        want.n = want.result[63];
                        want.z = (want.result == 0);
                        expected_q.push_back(want);
                    end
                    MODE_EXEC: expected_q.push_back(execute_insn(s_instruction, s_pc));
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: sim/tb.sv
// Testbench top for rv64im_decode_execute_core: clock, reset, stimulus and verdict.
// Depends on rvde_pkg, the core and rvde_checker.
module tb;
    import rvde_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic [1:0]         s_mode = MODE_NONE;
    logic [31:0]        s_instruction = 0;
    logic [63:0]        s_pc = 0;
    logic [4:0]         s_reg_index = 0;
    logic signed [63:0] s_reg_value = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic [3:0]         m_category;
    logic               m_not_32bit;
    logic [4:0]         m_dest_reg;
    logic [2:0]         m_funct3;
    logic [6:0]         m_funct7;
    logic signed [12:0] m_offset;
    logic signed [63:0] m_result;
    logic               m_flag_n, m_flag_z, m_flag_c, m_flag_v;
    int                 err_count, pending;
    int                 idle_cycles = 0;
    int                 burst_left = 0;

    always #5 aclk = ~aclk;

    rv64im_decode_execute_core dut (.*);
    rvde_checker chk (.*);

    // receiver stall pattern: runs of ready and not-ready of random length
    int stall_run = 0;
    always @(negedge aclk) begin
        if (stall_run == 0) begin
            m_ready <= ~m_ready;
            stall_run = m_ready ? $urandom_range(0, 6) : $urandom_range(1, 20);
        end else begin
            stall_run--;
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog expired");
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // present one transaction and hold it until accepted; drop valid at the end of a burst
    task automatic send_item(input mode_t m, input logic [31:0] ins, input logic [63:0] pc,
                             input logic [4:0] idx, input logic [63:0] val);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_valid <= 1;
        s_mode <= m;
        s_instruction <= ins;
        s_pc <= pc;
        s_reg_index <= idx;
        s_reg_value <= val;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (burst_left == 0) s_valid <= 0;
    endtask

    // close the current burst before a pause
    task automatic end_burst();
        if (burst_left != 0) s_valid <= 0;
        burst_left = 0;
    endtask

    function automatic logic [63:0] rand64();
        logic [63:0] x;
        x = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: x = 0;
            1: x = '1;
            2: x = SIGN64;
            3: x = ~SIGN64;
            4: x = 64'($urandom_range(0, 40));
            default: ;
        endcase
        return x;
    endfunction

    // instruction word with random fields; most have low bits 11 and a known opcode
    function automatic logic [31:0] rand_insn();
        logic [4:0]  opcs [12] = '{5'b00000, 5'b00100, 5'b00101, 5'b00110, 5'b01000,
                                   5'b01100, 5'b01101, 5'b01110, 5'b11000, 5'b11001,
                                   5'b11011, 5'b11100};
        logic [6:0]  f7s [4] = '{7'd0, 7'd1, 7'd32, 7'd0};
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0: return w;
            1: w[6:2] = 5'($urandom);
            default: w[6:2] = opcs[$urandom_range(0, 11)];
        endcase
        w[1:0] = 2'b11;
        if ($urandom_range(0, 3) != 0) w[31:25] = f7s[$urandom_range(0, 3)];
        return w;
    endfunction

    logic [31:0] directed [] = '{
        32'h0000_0013, 32'hfff1_0093, 32'h0011_1093, 32'h4030_5093, 32'h0030_5093,
        32'h0000_0000, 32'hffff_fffc, 32'h0020_8133, 32'h4020_81b3, 32'h0220_c233,
        32'h0220_52b3, 32'h0220_e333, 32'h0220_f3bb, 32'h0220_d43b, 32'hfe20_8fe3,
        32'hfe11_3c23, 32'hfff0_0517, 32'h8000_05b7, 32'h01f1_161b, 32'h4011_561b,
        32'h0000_006f, 32'h0000_0073, 32'hffff_ffff, 32'h0020_f7b3};

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        // directed: extreme register values, special cases and every category but LOAD and JALR
        send_item(MODE_READ, 0, 0, 5'd2, 0);
        send_item(MODE_WRITE, 0, 0, 5'd1, SIGN64);
        send_item(MODE_WRITE, 0, 0, 5'd2, '1);
        send_item(MODE_WRITE, 0, 0, 5'd31, 64'h7fff_ffff_ffff_ffff);
        send_item(MODE_NONE, '1, '1, 5'd31, '1);
        send_item(MODE_READ, 0, 0, 5'd1, 0);
        foreach (directed[i])
            send_item(MODE_EXEC, directed[i], 64'hffff_ffff_ffff_f000, 0, 0);
        // hold off until every outstanding result is back
        end_burst();
        wait (pending == 0);
        // random traffic
        for (int n = 0; n < 1150; n++) begin
            int pick;
            pick = $urandom_range(0, 99);
            if (pick < 20)
                send_item(MODE_WRITE, 0, 0, 5'($urandom), rand64());
            else if (pick < 28)
                send_item(MODE_READ, $urandom, rand64(), 5'($urandom), rand64());
            else if (pick < 30)
                send_item(MODE_NONE, $urandom, rand64(), 5'($urandom), rand64());
            else
                send_item(MODE_EXEC, rand_insn(), rand64(), 5'($urandom), rand64());
            if (n == 600) begin
                end_burst();
                wait (pending == 0);
            end
        end
        end_burst();
        wait (pending == 0);
        repeat (100) @(posedge aclk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
